@@ design/rsi_pkg.sv @@
package rsi_pkg;
  localparam int FracBits = 16;
  localparam int AvgBits = 64;
  localparam int QuotBits = 23;
  localparam int LenBits = 16;
  localparam int IdxBits = 17;
  localparam logic [QuotBits-1:0] RsiNoLoss = 23'd6488712;
  localparam logic [QuotBits-1:0] RsiScale = 23'd6553600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_G,
    ST_DIV_L,
    ST_MUL,
    ST_DIV_R,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctl_t;
endpackage

@@ design/relative_strength_index_top.sv @@
// During warm-up the result is presented the cycle after the input transfer. Once valid,
// a result takes two average divides, a scale multiply and an RSI divide, all bit-serial;
// the RSI divide is skipped when the loss average is zero.
// Throughput: one item at a time; the next is accepted the cycle after the result transfer.
// Reset (rst_ni, async active low) clears the series state and sets window_length to 14.
module relative_strength_index_top #(
  parameter int PRICE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // close_price
  input  logic        s_axis_tuser,  // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // rsi_value[22:0], zero pad
  output logic        m_axis_tuser   // rsi_valid
);
  import rsi_pkg::*;
  localparam int NW = AvgBits + QuotBits + 1;

  state_e st_q, st_d;
  logic [LenBits-1:0] len_q;
  logic [PRICE_BITS-1:0] prev_q, price;
  logic [IdxBits-1:0] idx_q, p;
  logic [AvgBits-1:0] gavg_q, lavg_q, gsum, lsum, nd, avg;
  logic [AvgBits-1:0] gx_q, lx_q;
  logic first_q;
  logic [QuotBits-1:0] rsi_q;
  logic vld_q, ovalid_q;
  logic [PRICE_BITS-1:0] g, l;
  logic restart;
  logic [IdxBits-1:0] idx_eff;
  logic [AvgBits-1:0] gprev, lprev;

  logic [NW-1:0] dnum, dquo;
  logic [AvgBits:0] dden, drem;
  logic ddone;
  logic mstart, mdone;
  logic [NW-1:0] mprod;
  logic [NW-1:0] prod_q;
  logic sel_l_q;

  assign price = PRICE_BITS'(s_axis_tdata);
  assign restart = s_axis_tuser;
  assign p = (len_q == '0) ? IdxBits'(1) : {1'b0, len_q};
  assign s_axis_tready = st_q == ST_IDLE && !ovalid_q;
  wire acc = s_axis_tvalid && s_axis_tready;
  assign idx_eff = restart ? '0 : idx_q;
  assign gprev = restart ? '0 : gavg_q;
  assign lprev = restart ? '0 : lavg_q;
  wire [PRICE_BITS-1:0] pp = restart ? '0 : prev_q;
  assign g = (price > pp) ? price - pp : '0;
  assign l = (price > pp) ? '0 : pp - price;
  assign gsum = gprev + AvgBits'(g);
  assign lsum = lprev + AvgBits'(l);

  // operands for current divide
  logic [AvgBits-1:0] cur_avg, cur_x;
  assign cur_avg = sel_l_q ? lavg_q : gavg_q;
  assign cur_x = sel_l_q ? lx_q : gx_q;
  assign nd = (cur_x >= cur_avg) ? cur_x - cur_avg : cur_avg - cur_x;

  always_comb begin
    dnum = '0;
    dden = {{(AvgBits+1-IdxBits){1'b0}}, p};
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (acc && idx_eff != '0 && idx_eff >= p) begin
        st_d = ST_DIV_G;
      end
      ST_DIV_G, ST_DIV_L: begin
        if (first_q) dnum = {cur_x, {(NW-AvgBits){1'b0}}} >> (QuotBits + 1 - FracBits);
        else dnum = NW'(nd);
        if (ddone) st_d = (st_q == ST_DIV_G) ? ST_DIV_L : ST_MUL;
      end
      ST_MUL: if (mdone) begin
        st_d = (lavg_q == '0) ? ST_OUT : ST_DIV_R;
      end
      ST_DIV_R: begin
        dnum = prod_q;
        dden = {1'b0, gavg_q} + {1'b0, lavg_q};
        if (ddone) st_d = ST_OUT;
      end
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // start pulses generated on state entry
  state_e st_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_p_q <= ST_IDLE;
    else st_p_q <= st_q;
  end
  logic dstart;
  assign dstart = (st_q != st_p_q) &&
                  (st_q == ST_DIV_G || st_q == ST_DIV_L || st_q == ST_DIV_R);
  assign mstart = (st_q != st_p_q) && st_q == ST_MUL;
  div_ctl_t dctl;
  assign dctl.start = dstart;

  rsi_div u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .num_i(dnum), .den_i(dden),
    .quo_o(dquo), .rem_o(drem), .done_o(ddone)
  );
  rsi_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(gavg_q), .prod_o(mprod), .done_o(mdone)
  );

  // divider result to average
  logic [AvgBits-1:0] q64;
  assign q64 = dquo[AvgBits-1:0];
  always_comb begin
    if (first_q) avg = q64;
    else if (cur_x >= cur_avg) avg = cur_avg + q64;
    else avg = cur_avg - q64 - AvgBits'(drem != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      len_q <= 16'd14;
      prev_q <= '0;
      idx_q <= '0;
      gavg_q <= '0;
      lavg_q <= '0;
      ovalid_q <= 1'b0;
      vld_q <= 1'b0;
      rsi_q <= '0;
      sel_l_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
        prev_q <= '0;
        idx_q <= '0;
        gavg_q <= '0;
        lavg_q <= '0;
      end else if (acc) begin
        prev_q <= price;
        if (idx_eff == '0) begin
          idx_q <= IdxBits'(1);
          gavg_q <= gprev;
          lavg_q <= lprev;
          rsi_q <= '0;
          vld_q <= 1'b0;
          ovalid_q <= 1'b1;
        end else if (idx_eff < p) begin
          gavg_q <= gsum;
          lavg_q <= lsum;
          idx_q <= idx_eff + 1'b1;
          rsi_q <= '0;
          vld_q <= 1'b0;
          ovalid_q <= 1'b1;
        end else begin
          first_q <= idx_eff == p;
          idx_q <= p + 1'b1;
          sel_l_q <= 1'b0;
          if (idx_eff == p) begin
            gx_q <= gsum;
            lx_q <= lsum;
          end else begin
            gavg_q <= gprev;
            lavg_q <= lprev;
            gx_q <= AvgBits'(g) << FracBits;
            lx_q <= AvgBits'(l) << FracBits;
          end
        end
      end else begin
        if (ddone && st_q == ST_DIV_G) begin
          gavg_q <= avg;
          sel_l_q <= 1'b1;
        end
        if (ddone && st_q == ST_DIV_L) lavg_q <= avg;
        if (ddone && st_q == ST_DIV_R) rsi_q <= dquo[QuotBits-1:0];
        if (mdone && lavg_q == '0) rsi_q <= RsiNoLoss;
        if (st_q == ST_OUT) begin
          vld_q <= 1'b1;
          ovalid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mdone) prod_q <= mprod;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {1'b0, rsi_q};
  assign m_axis_tuser = vld_q;
endmodule

@@ design/rsi_div.sv @@
module rsi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rsi_pkg::div_ctl_t          ctl_i,
  input  logic [rsi_pkg::AvgBits+rsi_pkg::QuotBits:0] num_i,
  input  logic [rsi_pkg::AvgBits:0]  den_i,
  output logic [rsi_pkg::AvgBits+rsi_pkg::QuotBits:0] quo_o,
  output logic [rsi_pkg::AvgBits:0]  rem_o,
  output logic                       done_o
);
  import rsi_pkg::*;
  localparam int NW = AvgBits + QuotBits + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_q, q_d;
  logic [AvgBits+1:0] r_q, r_d;
  logic [AvgBits:0] d_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic run_q, run_d;
  logic done_q;
  logic [AvgBits+1:0] sh;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    run_d = run_q;
    sh = {r_q[AvgBits:0], q_q[NW-1]};
    if (ctl_i.start) begin
      q_d = num_i;
      r_d = '0;
      cnt_d = CW'(NW);
      run_d = 1'b1;
    end else if (run_q) begin
      q_d = {q_q[NW-2:0], 1'b0};
      if (sh >= {1'b0, d_q}) begin
        r_d = sh - {1'b0, d_q};
        q_d[0] = 1'b1;
      end else begin
        r_d = sh;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      done_q <= run_q && cnt_q == CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (ctl_i.start) d_q <= den_i;
  end

  assign quo_o = q_q;
  assign rem_o = r_q[AvgBits:0];
  assign done_o = done_q;
endmodule

@@ design/rsi_mul.sv @@
module rsi_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsi_pkg::AvgBits-1:0] a_i,
  output logic [rsi_pkg::AvgBits+rsi_pkg::QuotBits:0] prod_o,
  output logic                      done_o
);
  import rsi_pkg::*;
  localparam int PW = AvgBits + QuotBits + 1;
  localparam int CW = $clog2(QuotBits + 1);
  logic [PW-1:0] acc_q, acc_d, a_q, a_d;
  logic [QuotBits-1:0] b_q, b_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic run_q, run_d;
  logic done_q;

  always_comb begin
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      acc_d = '0;
      a_d = PW'(a_i);
      b_d = RsiScale;
      cnt_d = CW'(QuotBits);
      run_d = 1'b1;
    end else if (run_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = {a_q[PW-2:0], 1'b0};
      b_d = {1'b0, b_q[QuotBits-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      done_q <= run_q && cnt_q == CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;
endmodule

@@ design/rsi_checker.sv @@
module rsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 24'd6553600) else $error("rsi out of range");
  a_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == 24'd0) else $error("warmup nonzero");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind relative_strength_index_top rsi_checker u_rsi_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

@@ bench/tb_relative_strength_index_top.sv @@
`timescale 1ns / 1ps

module tb_relative_strength_index_top;
  import rsi_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 400;

  typedef struct {
    logic [31:0] price;
    logic        restart;
  } price_item_t;

  typedef struct {
    logic [22:0] value;
    logic        valid;
  } rsi_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  relative_strength_index_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state
  logic [15:0] win_len;
  logic [31:0] last_price;
  logic [16:0] sample_cnt;
  logic [63:0] gain_avg;
  logic [63:0] loss_avg;

  price_item_t pending_prices[$];
  rsi_result_t expected_rsi[$];
  int          error_cnt;
  int          cycle_cnt;
  bit          in_took;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  bit          hold_req;
  int          stall_mode;
  int          mode_left;
  logic [31:0] walk_price;

  function automatic logic [63:0] avg_of_sum(input logic [63:0] sum, input logic [63:0] p);
    return ((sum / p) << FracBits) + (((sum % p) << FracBits) / p);
  endfunction

  function automatic logic [63:0] wilder_step(input logic [63:0] avg, input logic [63:0] x,
                                              input logic [63:0] p);
    logic [63:0] d;
    logic [63:0] q;
    if (x >= avg) return avg + (x - avg) / p;
    d = avg - x;
    q = d / p;
    if (d % p != 0) q = q + 1;
    return avg - q;
  endfunction

  function automatic logic [22:0] rsi_of_avgs(input logic [63:0] g, input logic [63:0] l);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    if (l == 0) return RsiNoLoss;
    num = {64'd0, g} * 128'd6553600;
    den = {64'd0, g} + {64'd0, l};
    q = num / den;
    return q[22:0];
  endfunction

  task automatic clear_series();
    last_price = '0;
    sample_cnt = '0;
    gain_avg = '0;
    loss_avg = '0;
  endtask

  task automatic predict_rsi(input price_item_t it, output rsi_result_t res);
    logic [63:0] p;
    logic [63:0] g;
    logic [63:0] l;
    p = (win_len == 0) ? 64'd1 : {48'd0, win_len};
    g = '0;
    l = '0;
    res.value = '0;
    res.valid = 1'b0;
    if (it.restart) clear_series();
    if (sample_cnt == 0) begin
      last_price = it.price;
      sample_cnt = 17'd1;
      return;
    end
    if (it.price > last_price) g = {32'd0, it.price - last_price};
    else l = {32'd0, last_price - it.price};
    last_price = it.price;
    if ({47'd0, sample_cnt} < p) begin
      gain_avg = gain_avg + g;
      loss_avg = loss_avg + l;
      sample_cnt = sample_cnt + 17'd1;
      return;
    end
    if ({47'd0, sample_cnt} == p) begin
      gain_avg = avg_of_sum(gain_avg + g, p);
      loss_avg = avg_of_sum(loss_avg + l, p);
      sample_cnt = p[16:0] + 17'd1;
    end else begin
      gain_avg = wilder_step(gain_avg, g << FracBits, p);
      loss_avg = wilder_step(loss_avg, l << FracBits, p);
    end
    res.value = rsi_of_avgs(gain_avg, loss_avg);
    res.valid = 1'b1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  // input side transfer + output checking
  always @(posedge clk_i) begin
    rsi_result_t exp_r;
    price_item_t it;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_relative_strength_index_top: done, errors");
      $finish;
    end else begin
      if (rst_ni && s_axis_tvalid && s_axis_tready) begin
        it.price = s_axis_tdata;
        it.restart = s_axis_tuser;
        predict_rsi(it, exp_r);
        expected_rsi = {expected_rsi, exp_r};
        in_took = 1'b1;
      end
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_rsi.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = expected_rsi.pop_front();
          if (m_axis_tdata !== {1'b0, exp_r.value})
            report_mismatch($sformatf("rsi_value got %h exp %h", m_axis_tdata, exp_r.value));
          if (m_axis_tuser !== exp_r.valid)
            report_mismatch($sformatf("rsi_valid got %b exp %b", m_axis_tuser, exp_r.valid));
        end
      end
    end
  end

  // driver: bursts with random gaps
  always @(negedge clk_i) begin
    price_item_t it;
    if (rst_ni && !(s_axis_tvalid && !in_took)) begin
      in_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_prices.size() > 0) begin
        it = pending_prices.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.price;
        s_axis_tuser <= it.restart;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 800);
      stall_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_mode == 1) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic add_price(input logic [31:0] price, input logic restart);
    price_item_t it;
    it.price = price;
    it.restart = restart;
    pending_prices = {pending_prices, it};
  endtask

  task automatic add_series(input int n);
    int kind;
    int step;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        walk_price = $urandom();
        add_price(walk_price, 1'b1);
      end else if (kind < 8) begin
        walk_price = $urandom();
        add_price(walk_price, 1'b0);
      end else if (kind < 15) begin
        add_price(walk_price, 1'b0);
      end else begin
        step = $urandom_range(0, 2000);
        if (kind < 40) walk_price = walk_price + step;
        else if (kind < 70) walk_price = walk_price - step;
        else walk_price = walk_price + step - 1000;
        add_price(walk_price, 1'b0);
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_prices.size() != 0 || s_axis_tvalid || expected_rsi.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_win_len(input logic [15:0] val);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 16'($urandom());
    win_len = val;
    clear_series();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    error_cnt = 0;
    cycle_cnt = 0;
    in_took = 1'b0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold_req = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    win_len = 16'd14;
    walk_price = 32'd100000;
    clear_series();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, window 14: extremes, flat, all-up, restart
    add_price(32'd0, 1'b0);
    add_price(32'hFFFF_FFFF, 1'b0);
    add_price(32'd0, 1'b0);
    for (int i = 0; i < 12; i++) add_price(32'd0, 1'b0);
    add_price(32'd0, 1'b0);
    add_price(32'd5, 1'b1);
    for (int i = 0; i < 15; i++) add_price(32'd5 + i * 7, 1'b0);
    add_price(32'hFFFF_FFFF, 1'b0);
    add_price(32'd0, 1'b0);
    wait_quiet();

    write_win_len(16'd1);
    add_price(32'd10, 1'b0);
    add_price(32'd10, 1'b0);
    add_price(32'hFFFF_FFFF, 1'b0);
    add_price(32'd0, 1'b0);
    add_series(150);
    hold_req = 1'b1;
    add_series(60);

    write_win_len(16'd0);
    add_series(150);

    write_win_len(16'hFFFF);
    add_series(30);

    write_win_len(16'd2);
    add_series(220);

    write_win_len(16'd5);
    add_series(230);

    write_win_len(16'd3);
    add_series(200);

    write_win_len(16'd20);
    add_series(220);

    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0 && expected_rsi.size() == 0) begin
      $display("tb_relative_strength_index_top: done, clean");
    end else begin
      if (expected_rsi.size() != 0) report_mismatch("expected results left over");
      $display("tb_relative_strength_index_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rsi_pkg.sv
design/rsi_div.sv
design/rsi_mul.sv
design/relative_strength_index_top.sv
design/rsi_checker.sv
bench/tb_relative_strength_index_top.sv
